// File: design/baro_comp_pkg.sv
// shared types and constants for the barometric compensation core
// no dependencies; used by baro_comp_div and baro_sensor_compensation_core
package baro_comp_pkg;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_COEFFS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_A      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_B      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_NINE   = 2'd3;

   // divider geometry: 64-bit dividend magnitude, divisor magnitude up to 2^30
   localparam int unsigned DIV_STEPS = 64;
   localparam int unsigned DEN_W     = 32;

   // side data that rides along with each transaction through the divider
   typedef struct packed {
      logic        neg;
      logic        bad;
      logic [27:0] tc;
      logic [31:0] tf;
   } div_side_type;

endpackage

// File: design/baro_comp_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on baro_comp_pkg for geometry and the side data type
module baro_comp_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_vld,
   input  logic [baro_comp_pkg::DIV_STEPS-1:0]    in_num,
   input  logic [baro_comp_pkg::DEN_W-1:0]        in_den,
   input  baro_comp_pkg::div_side_type            in_side,
   output logic                                   out_vld,
   output logic [baro_comp_pkg::DIV_STEPS-1:0]    out_quo,
   output baro_comp_pkg::div_side_type            out_side
);

   localparam int unsigned N = baro_comp_pkg::DIV_STEPS;
   localparam int unsigned W = baro_comp_pkg::DEN_W;

   logic                        vld_ff  [N];
   logic [W-1:0]                rem_ff  [N];
   logic [N-1:0]                dq_ff   [N];
   logic [W-1:0]                den_ff  [N];
   baro_comp_pkg::div_side_type side_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_step
      logic                        vld_prev;
      logic [W-1:0]                rem_prev;
      logic [N-1:0]                dq_prev;
      logic [W-1:0]                den_prev;
      baro_comp_pkg::div_side_type side_prev;
      logic [W:0]                  trial;
      logic [W:0]                  diff;
      logic [W-1:0]                rem_in;
      logic [N-1:0]                dq_in;

      if (j == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign rem_prev  = '0;
         assign dq_prev   = in_num;
         assign den_prev  = in_den;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign dq_prev   = dq_ff[j-1];
         assign den_prev  = den_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      always_comb begin
         trial = {rem_prev, dq_prev[N-1]};
         diff  = trial - {1'b0, den_prev};
         if (trial >= {1'b0, den_prev}) begin
            rem_in = diff[W-1:0];
            dq_in  = {dq_prev[N-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            dq_in  = {dq_prev[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            dq_ff[j]   <= dq_in;
            den_ff[j]  <= den_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_quo  = dq_ff[N-1];
   assign out_side = side_ff[N-1];

endmodule

// File: design/baro_sensor_compensation_core.sv
// top level of the barometric sensor compensation core
// depends on baro_comp_pkg and baro_comp_div
//
// usage
//   req channel: one transaction carries a raw 20-bit temperature and a raw
//     20-bit pressure sample. valid/ready, accepted when both are high
//   rsp channel: one transaction per request, in order: temperature in
//     0.01 degC, fine temperature, pressure in Pa as Q24.8 and an invalid
//     flag (pressure divisor was zero, pressure forced to 0)
//   csr port: write-only, csr_write_enable/csr_index/csr_write_data. holds
//     the packed factory coefficients; write only while the core is idle
//   latency: rsp_valid rises 81 cycles after the request edge: 10 stages of
//     multiply/add, 64 divider stages (one quotient bit each), 6 stages of
//     pressure correction and the output register
//   throughput: one transaction per cycle, set by the fully pipelined
//     divider and multiplier stages
//   reset: synchronous, clears coefficients to zero and drops all valids
//   stall: while rsp_ready is low the pipeline runs one more cycle into a
//     skid register, then freezes and req_ready drops; nothing is lost
module baro_sensor_compensation_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_write_enable,
   input  logic [baro_comp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [baro_comp_pkg::CSR_DATA_W-1:0]   csr_write_data,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [19:0]                            req_raw_temperature,
   input  logic [19:0]                            req_raw_pressure,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [27:0]                     rsp_temperature_centi,
   output logic signed [31:0]                     rsp_fine_temperature,
   output logic signed [31:0]                     rsp_pressure_q24_8,
   output logic                                   rsp_invalid
);

   // ------------------------------------------------------------------
   // coefficient registers
   // ------------------------------------------------------------------
   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [15:0] press_nine_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         press_nine_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            baro_comp_pkg::CSR_TEMP_COEFFS: temp_coeffs_ff <= csr_write_data[47:0];
            baro_comp_pkg::CSR_PRESS_A:     press_a_ff     <= csr_write_data;
            baro_comp_pkg::CSR_PRESS_B:     press_b_ff     <= csr_write_data;
            baro_comp_pkg::CSR_PRESS_NINE:  press_nine_ff  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // unpacked coefficients
   logic        [15:0] t1;
   logic signed [15:0] t2s, t3s;
   logic        [15:0] p1;
   logic signed [15:0] p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;

   assign t1  = temp_coeffs_ff[15:0];
   assign t2s = $signed(temp_coeffs_ff[31:16]);
   assign t3s = $signed(temp_coeffs_ff[47:32]);
   assign p1  = press_a_ff[15:0];
   assign p2s = $signed(press_a_ff[31:16]);
   assign p3s = $signed(press_a_ff[47:32]);
   assign p4s = $signed(press_a_ff[63:48]);
   assign p5s = $signed(press_b_ff[15:0]);
   assign p6s = $signed(press_b_ff[31:16]);
   assign p7s = $signed(press_b_ff[47:32]);
   assign p8s = $signed(press_b_ff[63:48]);
   assign p9s = $signed(press_nine_ff);

   // ------------------------------------------------------------------
   // flow control: whole pipeline advances unless the skid register is full
   // ------------------------------------------------------------------
   logic adv;
   logic skid_vld_ff;
   logic rsp_vld_ff;

   assign adv       = !skid_vld_ff;
   assign req_ready = !skid_vld_ff;

   // ------------------------------------------------------------------
   // temperature path, 32-bit wrap
   // ------------------------------------------------------------------
   // stage 1: first products
   logic signed [17:0] xt;
   logic signed [33:0] a_full;
   logic signed [16:0] dt;
   logic signed [33:0] dd_full;

   always_comb begin
      xt      = $signed({1'b0, req_raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
      a_full  = xt * t2s;
      dt      = $signed({1'b0, req_raw_temperature[19:4]}) - $signed({1'b0, t1});
      dd_full = dt * dt;
   end

   logic        s1_vld_ff;
   logic [31:0] s1_a_ff, s1_dd_ff;
   logic [19:0] s1_rp_ff;

   // stage 2: shift and the t3 product
   logic signed [19:0] dd_sh;
   logic signed [35:0] vb_full;
   logic        [31:0] s2_va_in;

   always_comb begin
      dd_sh    = $signed(s1_dd_ff[31:12]);
      vb_full  = dd_sh * t3s;
      s2_va_in = {{11{s1_a_ff[31]}}, s1_a_ff[31:11]};
   end

   logic        s2_vld_ff;
   logic [31:0] s2_va_ff, s2_vb_ff;
   logic [19:0] s2_rp_ff;

   // stage 3: fine temperature
   logic [31:0] s3_tf_in;
   assign s3_tf_in = s2_va_ff + {{14{s2_vb_ff[31]}}, s2_vb_ff[31:14]};

   logic        s3_vld_ff;
   logic [31:0] s3_tf_ff;
   logic [19:0] s3_rp_ff;

   // stage 4: centi-degree rounding and start of the pressure path
   logic [31:0]        t5;
   logic signed [33:0] s4_v1_in;

   always_comb begin
      t5       = (s3_tf_ff << 2) + s3_tf_ff + 32'd128;
      s4_v1_in = $signed({{2{s3_tf_ff[31]}}, s3_tf_ff}) - 34'sd128000;
   end

   logic               s4_vld_ff;
   logic [27:0]        s4_tc_ff;
   logic [31:0]        s4_tf_ff;
   logic signed [33:0] s4_v1_ff;
   logic [19:0]        s4_rp_ff;

   // ------------------------------------------------------------------
   // pressure path, 64-bit wrap
   // ------------------------------------------------------------------
   // stage 5: square of var1 and the p5/p2 products
   logic signed [67:0] sq_full;
   logic signed [49:0] m5_in, m2_in;

   always_comb begin
      sq_full = s4_v1_ff * s4_v1_ff;
      m5_in   = s4_v1_ff * p5s;
      m2_in   = s4_v1_ff * p2s;
   end

   logic               s5_vld_ff;
   logic [63:0]        s5_sq_ff;
   logic signed [49:0] s5_m5_ff, s5_m2_ff;
   logic [27:0]        s5_tc_ff;
   logic [31:0]        s5_tf_ff;
   logic [19:0]        s5_rp_ff;

   // stage 6: square times p6 and p3, p5/p4 offset term
   logic signed [79:0] v2a_full, sq3_full;
   logic [63:0]        part_in;

   always_comb begin
      v2a_full = $signed(s5_sq_ff) * p6s;
      sq3_full = $signed(s5_sq_ff) * p3s;
      part_in  = ({{14{s5_m5_ff[49]}}, s5_m5_ff} << 17)
               + ({{48{p4s[15]}}, p4s} << 35);
   end

   logic               s6_vld_ff;
   logic [63:0]        s6_v2a_ff, s6_sq3_ff, s6_part_ff;
   logic signed [49:0] s6_m2_ff;
   logic [27:0]        s6_tc_ff;
   logic [31:0]        s6_tf_ff;
   logic [19:0]        s6_rp_ff;

   // stage 7: var2 and var1 sums
   logic [63:0] s7_v2_in, s7_v1b_in;

   always_comb begin
      s7_v2_in  = s6_v2a_ff + s6_part_ff;
      s7_v1b_in = {{8{s6_sq3_ff[63]}}, s6_sq3_ff[63:8]}
                + ({{14{s6_m2_ff[49]}}, s6_m2_ff} << 12);
   end

   logic        s7_vld_ff;
   logic [63:0] s7_v2_ff, s7_v1b_ff;
   logic [27:0] s7_tc_ff;
   logic [31:0] s7_tf_ff;
   logic [19:0] s7_rp_ff;

   // stage 8: p1 scaling of the divisor, dividend difference
   logic [63:0]        v1b_off;
   logic signed [80:0] v1c_full;
   logic [20:0]        pv;
   logic [63:0]        s8_diff_in;

   always_comb begin
      v1b_off    = s7_v1b_ff + (64'd1 << 47);
      v1c_full   = $signed(v1b_off) * $signed({1'b0, p1});
      pv         = 21'd1048576 - {1'b0, s7_rp_ff};
      s8_diff_in = {12'd0, pv, 31'd0} - s7_v2_ff;
   end

   logic        s8_vld_ff;
   logic [63:0] s8_v1c_ff, s8_diff_ff;
   logic [27:0] s8_tc_ff;
   logic [31:0] s8_tf_ff;

   // stage 9: divisor shift, dividend times 3125
   logic [63:0] s9_num_in;
   assign s9_num_in = s8_diff_ff * 64'd3125;

   logic        s9_vld_ff;
   logic [30:0] s9_v1d_ff;
   logic [63:0] s9_num_ff;
   logic [27:0] s9_tc_ff;
   logic [31:0] s9_tf_ff;

   // stage 10: magnitudes and signs for the divider
   logic [31:0]                 den_ext;
   logic [63:0]                 s10_ua_in;
   logic [31:0]                 s10_ub_in;
   baro_comp_pkg::div_side_type s10_side_in;

   always_comb begin
      den_ext           = {s9_v1d_ff[30], s9_v1d_ff};
      s10_ua_in         = s9_num_ff[63] ? (64'd0 - s9_num_ff) : s9_num_ff;
      s10_ub_in         = den_ext[31]   ? (32'd0 - den_ext)   : den_ext;
      s10_side_in.neg   = s9_num_ff[63] ^ s9_v1d_ff[30];
      s10_side_in.bad   = (s9_v1d_ff == 31'd0);
      s10_side_in.tc    = s9_tc_ff;
      s10_side_in.tf    = s9_tf_ff;
   end

   logic                        s10_vld_ff;
   logic [63:0]                 s10_ua_ff;
   logic [31:0]                 s10_ub_ff;
   baro_comp_pkg::div_side_type s10_side_ff;

   // ------------------------------------------------------------------
   // divider, 64 stages
   // ------------------------------------------------------------------
   logic                        dv_vld;
   logic [63:0]                 dv_quo;
   baro_comp_pkg::div_side_type dv_side;

   baro_comp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (s10_vld_ff),
      .in_num   (s10_ua_ff),
      .in_den   (s10_ub_ff),
      .in_side  (s10_side_ff),
      .out_vld  (dv_vld),
      .out_quo  (dv_quo),
      .out_side (dv_side)
   );

   // ------------------------------------------------------------------
   // pressure correction
   // ------------------------------------------------------------------
   // stage d1: signed quotient
   logic [63:0] d1_p_in;
   assign d1_p_in = dv_side.neg ? (64'd0 - dv_quo) : dv_quo;

   logic                        d1_vld_ff;
   logic [63:0]                 d1_p_ff;
   baro_comp_pkg::div_side_type d1_side_ff;

   // stage d2: partial products of q*q (q = p >> 13) and p8*p
   logic [63:0]        qv;
   logic [63:0]        d2_ll_in;
   logic [63:0]        lh_full;
   logic signed [79:0] w2m_full;

   always_comb begin
      qv       = {{13{d1_p_ff[63]}}, d1_p_ff[63:13]};
      d2_ll_in = qv[31:0] * qv[31:0];
      lh_full  = qv[31:0] * qv[63:32];
      w2m_full = $signed(d1_p_ff) * p8s;
   end

   logic                        d2_vld_ff;
   logic [63:0]                 d2_p_ff, d2_ll_ff, d2_w2m_ff;
   logic [30:0]                 d2_lh_ff;
   baro_comp_pkg::div_side_type d2_side_ff;

   // stage d3: assemble q*q mod 2^64, shift p8 term
   logic [63:0] d3_qq_in, d3_w2_in;

   always_comb begin
      d3_qq_in = d2_ll_ff + {d2_lh_ff, 33'd0};
      d3_w2_in = {{19{d2_w2m_ff[63]}}, d2_w2m_ff[63:19]};
   end

   logic                        d3_vld_ff;
   logic [63:0]                 d3_p_ff, d3_qq_ff, d3_w2_ff;
   baro_comp_pkg::div_side_type d3_side_ff;

   // stage d4: p9 product
   logic signed [79:0] w1a_full;
   assign w1a_full = $signed(d3_qq_ff) * p9s;

   logic                        d4_vld_ff;
   logic [63:0]                 d4_p_ff, d4_w1a_ff, d4_w2_ff;
   baro_comp_pkg::div_side_type d4_side_ff;

   // stage d5: three-term sum
   logic [63:0] d5_s_in;
   assign d5_s_in = d4_p_ff + {{25{d4_w1a_ff[63]}}, d4_w1a_ff[63:25]} + d4_w2_ff;

   logic                        d5_vld_ff;
   logic [63:0]                 d5_s_ff;
   baro_comp_pkg::div_side_type d5_side_ff;

   // stage d6: final shift, p7 offset, zero on bad divisor
   logic [31:0] d6_press_in;

   always_comb begin
      d6_press_in = d5_s_ff[39:8] + {{12{p7s[15]}}, p7s, 4'd0};
      if (d5_side_ff.bad) begin
         d6_press_in = '0;
      end
   end

   logic                        d6_vld_ff;
   logic [31:0]                 d6_press_ff;
   baro_comp_pkg::div_side_type d6_side_ff;

   // ------------------------------------------------------------------
   // valid chain
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         s7_vld_ff  <= 1'b0;
         s8_vld_ff  <= 1'b0;
         s9_vld_ff  <= 1'b0;
         s10_vld_ff <= 1'b0;
         d1_vld_ff  <= 1'b0;
         d2_vld_ff  <= 1'b0;
         d3_vld_ff  <= 1'b0;
         d4_vld_ff  <= 1'b0;
         d5_vld_ff  <= 1'b0;
         d6_vld_ff  <= 1'b0;
      end else if (adv) begin
         s1_vld_ff  <= req_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= s4_vld_ff;
         s6_vld_ff  <= s5_vld_ff;
         s7_vld_ff  <= s6_vld_ff;
         s8_vld_ff  <= s7_vld_ff;
         s9_vld_ff  <= s8_vld_ff;
         s10_vld_ff <= s9_vld_ff;
         d1_vld_ff  <= dv_vld;
         d2_vld_ff  <= d1_vld_ff;
         d3_vld_ff  <= d2_vld_ff;
         d4_vld_ff  <= d3_vld_ff;
         d5_vld_ff  <= d4_vld_ff;
         d6_vld_ff  <= d5_vld_ff;
      end
   end

   // ------------------------------------------------------------------
   // datapath registers, no reset
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_a_ff     <= a_full[31:0];
         s1_dd_ff    <= dd_full[31:0];
         s1_rp_ff    <= req_raw_pressure;

         s2_va_ff    <= s2_va_in;
         s2_vb_ff    <= vb_full[31:0];
         s2_rp_ff    <= s1_rp_ff;

         s3_tf_ff    <= s3_tf_in;
         s3_rp_ff    <= s2_rp_ff;

         s4_tc_ff    <= {{4{t5[31]}}, t5[31:8]};
         s4_tf_ff    <= s3_tf_ff;
         s4_v1_ff    <= s4_v1_in;
         s4_rp_ff    <= s3_rp_ff;

         s5_sq_ff    <= sq_full[63:0];
         s5_m5_ff    <= m5_in;
         s5_m2_ff    <= m2_in;
         s5_tc_ff    <= s4_tc_ff;
         s5_tf_ff    <= s4_tf_ff;
         s5_rp_ff    <= s4_rp_ff;

         s6_v2a_ff   <= v2a_full[63:0];
         s6_sq3_ff   <= sq3_full[63:0];
         s6_part_ff  <= part_in;
         s6_m2_ff    <= s5_m2_ff;
         s6_tc_ff    <= s5_tc_ff;
         s6_tf_ff    <= s5_tf_ff;
         s6_rp_ff    <= s5_rp_ff;

         s7_v2_ff    <= s7_v2_in;
         s7_v1b_ff   <= s7_v1b_in;
         s7_tc_ff    <= s6_tc_ff;
         s7_tf_ff    <= s6_tf_ff;
         s7_rp_ff    <= s6_rp_ff;

         s8_v1c_ff   <= v1c_full[63:0];
         s8_diff_ff  <= s8_diff_in;
         s8_tc_ff    <= s7_tc_ff;
         s8_tf_ff    <= s7_tf_ff;

         s9_v1d_ff   <= s8_v1c_ff[63:33];
         s9_num_ff   <= s9_num_in;
         s9_tc_ff    <= s8_tc_ff;
         s9_tf_ff    <= s8_tf_ff;

         s10_ua_ff   <= s10_ua_in;
         s10_ub_ff   <= s10_ub_in;
         s10_side_ff <= s10_side_in;

         d1_p_ff     <= d1_p_in;
         d1_side_ff  <= dv_side;

         d2_p_ff     <= d1_p_ff;
         d2_ll_ff    <= d2_ll_in;
         d2_lh_ff    <= lh_full[30:0];
         d2_w2m_ff   <= w2m_full[63:0];
         d2_side_ff  <= d1_side_ff;

         d3_p_ff     <= d2_p_ff;
         d3_qq_ff    <= d3_qq_in;
         d3_w2_ff    <= d3_w2_in;
         d3_side_ff  <= d2_side_ff;

         d4_p_ff     <= d3_p_ff;
         d4_w1a_ff   <= w1a_full[63:0];
         d4_w2_ff    <= d3_w2_ff;
         d4_side_ff  <= d3_side_ff;

         d5_s_ff     <= d5_s_in;
         d5_side_ff  <= d4_side_ff;

         d6_press_ff <= d6_press_in;
         d6_side_ff  <= d5_side_ff;
      end
   end

   // ------------------------------------------------------------------
   // output register and skid register
   // ------------------------------------------------------------------
   logic                        out_take;
   logic [31:0]                 rsp_press_ff, skid_press_ff;
   baro_comp_pkg::div_side_type rsp_side_ff, skid_side_ff;

   assign out_take = !rsp_vld_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_vld_ff) begin
            rsp_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            rsp_vld_ff  <= d6_vld_ff;
         end
      end else if (d6_vld_ff && !skid_vld_ff) begin
         // receiver stalled: last stage spills into the skid register
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         if (skid_vld_ff) begin
            rsp_press_ff <= skid_press_ff;
            rsp_side_ff  <= skid_side_ff;
         end else begin
            rsp_press_ff <= d6_press_ff;
            rsp_side_ff  <= d6_side_ff;
         end
      end else if (!skid_vld_ff) begin
         skid_press_ff <= d6_press_ff;
         skid_side_ff  <= d6_side_ff;
      end
   end

   assign rsp_valid             = rsp_vld_ff;
   assign rsp_temperature_centi = $signed(rsp_side_ff.tc);
   assign rsp_fine_temperature  = $signed(rsp_side_ff.tf);
   assign rsp_pressure_q24_8    = $signed(rsp_press_ff);
   assign rsp_invalid           = rsp_side_ff.bad;

endmodule
